@@ hw/rtl/wvs_pkg.sv @@
// Shared types and constants for the water vertex shader.
// Used by wvs_front, wvs_queue, wvs_back and water_vertex_shader.
`default_nettype none
package wvs_pkg;

    localparam logic signed [15:0] L_X = 16'sd11584;
    localparam logic signed [15:0] L_Y = -16'sd8193;
    localparam logic signed [15:0] L_Z = 16'sd8193;
    localparam logic signed [15:0] H_X = 16'sd6688;
    localparam logic signed [15:0] H_Y = -16'sd4730;
    localparam logic signed [15:0] H_Z = 16'sd14189;

    localparam logic [14:0] LIGHT_CAP = 15'd19661;
    localparam logic [16:0] SAT_Q14   = 17'd65536;
    localparam logic [14:0] ONE_Q14   = 15'd16384;
    localparam logic [15:0] UNIT_RANGE = 16'd256;

    // Pipeline depth of the back end, one valid bit per stage
    localparam int BACK_DEPTH = 18;

    localparam logic [2:0] REG_WAVE_RANGE  = 3'd0;
    localparam logic [2:0] REG_AMBIENT     = 3'd1;
    localparam logic [2:0] REG_SPEC_GAIN   = 3'd2;
    localparam logic [2:0] REG_HEIGHT_BASE = 3'd3;
    localparam logic [2:0] REG_HEIGHT_SPAN = 3'd4;
    localparam logic [2:0] REG_WATER_COLOR = 3'd5;
    localparam logic [2:0] REG_MIN_BRIGHT  = 3'd6;
    localparam logic [2:0] REG_BORDER_FADE = 3'd7;

    typedef struct packed {
        logic [15:0] wave_range;
        logic [14:0] ambient_level;
        logic [14:0] specular_gain;
        logic [14:0] height_base;
        logic [14:0] height_span;
        logic [23:0] water_color;
        logic [7:0]  min_brightness;
        logic [16:0] border_fade;
    } t_cfg;

    typedef struct packed {
        logic [16:0]        row;
        logic signed [17:0] num;    // raw height plus effective range
        logic               hpos;   // num above zero
        logic               hfull;  // num at or above twice the range
        logic               band;   // row inside the fade band
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } t_item;

    function automatic logic [15:0] eff_range(input logic [15:0] r);
        eff_range = (r == 16'd0) ? UNIT_RANGE : r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/wvs_front.sv @@
// Front end: takes a vertex and classifies height and fade band.
// Depends on wvs_pkg; feeds wvs_queue.
`default_nettype none
module wvs_front import wvs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [16:0]        i_row,
    input  wire logic signed [15:0] i_raw,
    input  wire logic signed [15:0] i_nx,
    input  wire logic signed [15:0] i_ny,
    input  wire logic signed [15:0] i_nz,
    input  wire t_cfg               i_cfg,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_item                   o_item
);
    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic [15:0] range;
    logic        take;

    assign range = eff_range(i_cfg.wave_range);
    assign o_busy = r_valid && !i_ready;
    assign take = i_start && !o_busy;

    always_comb begin
        n_item.row   = i_row;
        n_item.num   = 18'(i_raw) + $signed({2'b00, range});
        n_item.hpos  = n_item.num > 18'sd0;
        n_item.hfull = n_item.hpos && (n_item.num[16:0] >= {range, 1'b0});
        n_item.band  = i_row < i_cfg.border_fade;
        n_item.nx    = i_nx;
        n_item.ny    = i_ny;
        n_item.nz    = i_nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule
`default_nettype wire

@@ hw/rtl/wvs_queue.sv @@
// Two-entry queue between front and back end.
// Depends on wvs_pkg for the item type.
`default_nettype none
module wvs_queue import wvs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_ready,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_item      o_item
);
    t_item      r_mem [0:1];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_ready = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/wvs_back.sv @@
// Back end: lighting, height division, smoothstep division and shading.
// Depends on wvs_pkg; fed by wvs_queue, one item per cycle.
`default_nettype none
module wvs_back import wvs_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_alpha
);
    logic [BACK_DEPTH-1:0] r_vld;
    logic [15:0]           range;

    assign range = eff_range(i_cfg.wave_range);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BACK_DEPTH-2:0], i_valid};
        end
    end

    // ---------------- stage 1
    logic signed [33:0] r1_dl, r1_dh;
    logic [33:0]        r1_y2, r1_b2;
    logic [18:0]        r1_t;
    logic               r1_band;
    logic [16:0]        r1_b;

    always_ff @(posedge i_clk) begin
        r1_dl   <= 34'(i_item.nx) * 34'(L_X) + 34'(i_item.ny) * 34'(L_Y)
                   + 34'(i_item.nz) * 34'(L_Z);
        r1_dh   <= 34'(i_item.nx) * 34'(H_X) + 34'(i_item.ny) * 34'(H_Y)
                   + 34'(i_item.nz) * 34'(H_Z);
        r1_y2   <= 34'(i_item.row) * 34'(i_item.row);
        r1_b2   <= 34'(i_cfg.border_fade) * 34'(i_cfg.border_fade);
        r1_t    <= (19'(i_cfg.border_fade) << 1) + 19'(i_cfg.border_fade)
                   - (19'(i_item.row) << 1);
        r1_band <= i_item.band;
        r1_b    <= i_cfg.border_fade;
    end

    // ---------------- height division, one quotient bit per stage
    logic [16:0] r_hr [0:14];
    logic [13:0] r_hq [0:14];
    logic        r_hp [0:14];
    logic        r_hf [0:14];

    always_ff @(posedge i_clk) begin
        r_hr[0] <= i_item.num[16:0];
        r_hq[0] <= '0;
        r_hp[0] <= i_item.hpos;
        r_hf[0] <= i_item.hfull;
    end

    for (genvar k = 1; k <= 14; k++) begin : g_hdiv
        logic [17:0] t;
        logic        ge;
        assign t  = (k == 1) ? {1'b0, r_hr[k-1]} : {r_hr[k-1], 1'b0};
        assign ge = t >= {2'b00, range};
        always_ff @(posedge i_clk) begin
            r_hr[k] <= ge ? 17'(t - {2'b00, range}) : t[16:0];
            r_hq[k] <= {r_hq[k-1][12:0], ge};
            r_hp[k] <= r_hp[k-1];
            r_hf[k] <= r_hf[k-1];
        end
    end

    logic [14:0] h15;
    assign h15 = !r_hp[14] ? 15'd0 : (r_hf[14] ? ONE_Q14 : {1'b0, r_hq[14]});

    // ---------------- lighting
    logic [19:0] r_diff [0:5];
    logic [16:0] r_p    [0:5];

    always_ff @(posedge i_clk) begin
        r_diff[0] <= (r1_dl > 34'sd0) ? r1_dl[33:14] : 20'd0;
        if (r1_dh <= 34'sd0) begin
            r_p[0] <= '0;
        end else if (r1_dh[33:14] > 20'(SAT_Q14)) begin
            r_p[0] <= SAT_Q14;
        end else begin
            r_p[0] <= r1_dh[30:14];
        end
    end

    for (genvar j = 1; j <= 5; j++) begin : g_sq
        logic [33:0] sq;
        assign sq = 34'(r_p[j-1]) * 34'(r_p[j-1]);
        always_ff @(posedge i_clk) begin
            r_p[j]    <= (sq[33:14] > 20'(SAT_Q14)) ? SAT_Q14 : sq[30:14];
            r_diff[j] <= r_diff[j-1];
        end
    end

    logic [17:0] r8_spec;
    logic [19:0] r8_diff;
    logic [31:0] spec_prod;
    assign spec_prod = 32'(i_cfg.specular_gain) * 32'(r_p[5]);

    always_ff @(posedge i_clk) begin
        r8_spec <= spec_prod[31:14];
        r8_diff <= r_diff[5];
    end

    logic [20:0] lsum;
    logic [14:0] r_lt [0:6];
    assign lsum = 21'(i_cfg.ambient_level) + 21'(r8_diff) + 21'(r8_spec);

    always_ff @(posedge i_clk) begin
        r_lt[0] <= (lsum > 21'(LIGHT_CAP)) ? LIGHT_CAP : lsum[14:0];
        for (int i = 1; i <= 6; i++) begin
            r_lt[i] <= r_lt[i-1];
        end
    end

    // ---------------- height effect and overall multiplier
    logic [29:0] eff_prod;
    logic [16:0] r16_eff;
    logic [14:0] r16_lt;
    logic [31:0] mult_prod;
    logic [17:0] r17_mult;

    assign eff_prod  = 30'(i_cfg.height_span) * 30'(h15);
    assign mult_prod = 32'(r16_lt) * 32'(r16_eff);

    always_ff @(posedge i_clk) begin
        r16_eff  <= 17'(i_cfg.height_base) + 17'(eff_prod[29:14]);
        r16_lt   <= r_lt[6];
        r17_mult <= mult_prod[31:14];
    end

    // ---------------- smoothstep alpha
    logic [63:0] r2_n0, r2_d;
    logic        r2_band;
    logic [63:0] r_an [0:8];
    logic [63:0] r_ad [0:8];
    logic [7:0]  r_aq [0:8];
    logic        r_ab [0:8];

    always_ff @(posedge i_clk) begin
        r2_n0   <= 64'(r1_y2) * 64'(r1_t);
        r2_d    <= 64'(r1_b2) * 64'(r1_b);
        r2_band <= r1_band;
        r_an[0] <= (r2_n0 << 8) - r2_n0;
        r_ad[0] <= r2_d;
        r_aq[0] <= '0;
        r_ab[0] <= r2_band;
    end

    for (genvar k = 1; k <= 8; k++) begin : g_adiv
        logic [63:0] dsh;
        logic        ge;
        assign dsh = r_ad[k-1] << (8 - k);
        assign ge  = r_an[k-1] >= dsh;
        always_ff @(posedge i_clk) begin
            r_an[k] <= ge ? r_an[k-1] - dsh : r_an[k-1];
            r_ad[k] <= r_ad[k-1];
            r_aq[k] <= {r_aq[k-1][6:0], ge};
            r_ab[k] <= r_ab[k-1];
        end
    end

    // Delay alpha to line up with the colour channels
    logic [7:0] r_al [0:5];
    always_ff @(posedge i_clk) begin
        r_al[0] <= r_ab[8] ? r_aq[8] : 8'd255;
        for (int i = 1; i <= 5; i++) begin
            r_al[i] <= r_al[i-1];
        end
    end

    // ---------------- shading
    function automatic logic [7:0] shade(input logic [7:0] c, input logic [17:0] m,
                                         input logic [7:0] lo);
        logic [25:0] prod;
        logic [11:0] v;
        prod = 26'(c) * 26'(m);
        v    = prod[25:14];
        if (v < 12'(lo)) v = 12'(lo);
        if (v > 12'd255) v = 12'd255;
        shade = v[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        o_red   <= shade(i_cfg.water_color[23:16], r17_mult, i_cfg.min_brightness);
        o_green <= shade(i_cfg.water_color[15:8], r17_mult, i_cfg.min_brightness);
        o_blue  <= shade(i_cfg.water_color[7:0], r17_mult, i_cfg.min_brightness);
        o_alpha <= r_al[5];
    end

    assign o_valid = r_vld[BACK_DEPTH-1];
endmodule
`default_nettype wire

@@ hw/rtl/water_vertex_shader.sv @@
// Water vertex shader: per-vertex Blinn-Phong colour and edge-fade alpha.
// From accept to o_done a vertex passes the front register, the queue and the 18-stage back end.
// Throughput: one vertex per cycle; the back end never stalls, so busy stays low.
// Reset (synchronous, active low) empties the pipeline and restores register defaults.
// Depends on wvs_pkg, wvs_front, wvs_queue, wvs_back.
`default_nettype none
module water_vertex_shader import wvs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [16:0]        i_row_position,
    input  wire logic signed [15:0] i_raw_height,
    input  wire logic signed [15:0] i_normal_x,
    input  wire logic signed [15:0] i_normal_y,
    input  wire logic signed [15:0] i_normal_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    output logic                    o_done,
    output logic [7:0]              o_red_out,
    output logic [7:0]              o_green_out,
    output logic [7:0]              o_blue_out,
    output logic [7:0]              o_alpha_out
);
    t_cfg  r_cfg;
    logic  f_valid, q_ready, q_valid;
    t_item f_item, q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_range     <= 16'd256;
            r_cfg.ambient_level  <= 15'd4915;
            r_cfg.specular_gain  <= 15'd8192;
            r_cfg.height_base    <= 15'd11469;
            r_cfg.height_span    <= 15'd4915;
            r_cfg.water_color    <= 24'h3366CC;
            r_cfg.min_brightness <= 8'd25;
            r_cfg.border_fade    <= 17'd6554;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WAVE_RANGE:  r_cfg.wave_range     <= i_cfg_data[15:0];
                REG_AMBIENT:     r_cfg.ambient_level  <= i_cfg_data[14:0];
                REG_SPEC_GAIN:   r_cfg.specular_gain  <= i_cfg_data[14:0];
                REG_HEIGHT_BASE: r_cfg.height_base    <= i_cfg_data[14:0];
                REG_HEIGHT_SPAN: r_cfg.height_span    <= i_cfg_data[14:0];
                REG_WATER_COLOR: r_cfg.water_color    <= i_cfg_data;
                REG_MIN_BRIGHT:  r_cfg.min_brightness <= i_cfg_data[7:0];
                REG_BORDER_FADE: r_cfg.border_fade    <= i_cfg_data[16:0];
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

    wvs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_row   (i_row_position),
        .i_raw   (i_raw_height),
        .i_nx    (i_normal_x),
        .i_ny    (i_normal_y),
        .i_nz    (i_normal_z),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .i_ready (q_ready),
        .o_item  (f_item)
    );

    wvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (1'b1),
        .o_item  (q_item)
    );

    wvs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .i_cfg   (r_cfg),
        .o_valid (o_done),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out),
        .o_alpha (o_alpha_out)
    );

    // Every result traces back to an accepted vertex a fixed time earlier
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 20))
        else $error("result without matching transaction");

    // Red and blue colour channels never drop below the brightness floor
    a_min_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_red_out >= r_cfg.min_brightness)
                && (o_blue_out >= r_cfg.min_brightness))
        else $error("channel below minimum brightness");

    // Outside the fade band alpha is fully opaque
    a_alpha_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_row_position >= r_cfg.border_fade)) |-> ##20
        (o_alpha_out == 8'd255))
        else $error("alpha not opaque outside fade band");
endmodule
`default_nettype wire
